@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the checker file fpa_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted.
`define FPA_ASSERT(name, prop, clk, rstn) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fixed point alu assertion failed");

// Concurrent assertion that also holds during reset.
`define FPA_ASSERT_ALWAYS(name, prop, clk) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("fixed point alu assertion failed");

`endif

@@ rtl/core/fpa_pkg.sv @@
// Package: opcodes and defaults of the fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned DataW       = 32;

  typedef enum logic [4:0] {
    OpAdd     = 5'd0,
    OpSub     = 5'd1,
    OpMul     = 5'd2,
    OpDiv     = 5'd3,
    OpNeg     = 5'd4,
    OpInc     = 5'd5,
    OpDec     = 5'd6,
    OpMin     = 5'd7,
    OpMax     = 5'd8,
    OpToInt   = 5'd9,
    OpFromInt = 5'd10,
    OpGt      = 5'd11,
    OpLt      = 5'd12,
    OpGe      = 5'd13,
    OpLe      = 5'd14,
    OpEq      = 5'd15,
    OpNe      = 5'd16
  } op_e;

  // Cycles from the accepting edge to the edge that takes the result.
  function automatic int unsigned latency(input int unsigned frac_bits);
    latency = 4 + DataW + frac_bits;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fixed_point_alu_core.sv @@
// Top level: pipelined signed fixed-point ALU.
`timescale 1ns / 1ps
`default_nettype none
// Signed 32-bit fixed-point ALU, FRAC_BITS fraction bits.
// Input: an item (op_i, operand_a_i, operand_b_i) is taken at every rising
// edge with start high and busy low. busy is always low: the pipeline takes
// one item every cycle.
// Output: each item yields one result on result_o, compare_true_o and
// div_by_zero_o, shown for exactly one cycle with done_o high.
// Order: every opcode runs the same path, so results leave in order. The
// restoring divider resolves one quotient bit per stage over 32 + FRAC_BITS
// stages.
// Stages: operand register, operation stage (simple ops, 32x32 multiply,
// divider setup), multiply scaling, divider bit stages, output register.
// Throughput: one item per cycle.
// Reset: clears all valid bits; no result is shown until new items arrive.
// The receiver cannot stall, so no backpressure path exists.
module fixed_point_alu_core #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [4:0]  op_i,
  input  wire logic signed [31:0] operand_a_i,
  input  wire logic signed [31:0] operand_b_i,
  output logic                    done_o,
  output logic signed [31:0]      result_o,
  output logic                    compare_true_o,
  output logic                    div_by_zero_o
);

  // quotient width: |a| << FRAC_BITS needs 32 + FRAC_BITS bits
  localparam int unsigned QW = fpa_pkg::DataW + FRAC_BITS;

  typedef struct packed {
    fpa_pkg::op_e   op;
    logic [31:0]    res;
    logic           cmp;
    logic           dz;
    logic           neg;
    logic [31:0]    den;
    logic [31:0]    rem;
    logic [QW-1:0]  num;   // dividend bits, quotient shifts in at the bottom
  } stg_t;

  assign busy = 1'b0;

  // ---- stage 1: operand register
  logic               s1_vld_q;
  logic [4:0]         s1_op_q;
  logic signed [31:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_op_q <= op_i;
    s1_a_q  <= operand_a_i;
    s1_b_q  <= operand_b_i;
  end

  // ---- stage 2: simple ops, multiply, divider setup
  stg_t               s2_d, s2_q;
  logic               s2_vld_q;
  logic signed [63:0] prod_d, prod_q;
  logic [31:0]        abs_a, abs_b;

  assign prod_d = s1_a_q * s1_b_q;
  assign abs_a  = s1_a_q[31] ? 32'(-s1_a_q) : 32'(s1_a_q);
  assign abs_b  = s1_b_q[31] ? 32'(-s1_b_q) : 32'(s1_b_q);

  always_comb begin
    s2_d     = '0;
    s2_d.op  = fpa_pkg::op_e'(s1_op_q);
    s2_d.neg = s1_a_q[31] ^ s1_b_q[31];
    s2_d.den = abs_b;
    s2_d.num = QW'(abs_a) << FRAC_BITS;
    case (s1_op_q)
      fpa_pkg::OpAdd:     s2_d.res = 32'(s1_a_q + s1_b_q);
      fpa_pkg::OpSub:     s2_d.res = 32'(s1_a_q - s1_b_q);
      fpa_pkg::OpDiv:     s2_d.dz  = (s1_b_q == 32'sd0);
      fpa_pkg::OpNeg:     s2_d.res = 32'(-s1_a_q);
      fpa_pkg::OpInc:     s2_d.res = 32'(s1_a_q + 32'sd1);
      fpa_pkg::OpDec:     s2_d.res = 32'(s1_a_q - 32'sd1);
      fpa_pkg::OpMin:     s2_d.res = (s1_a_q <= s1_b_q) ? s1_a_q : s1_b_q;
      fpa_pkg::OpMax:     s2_d.res = (s1_a_q >= s1_b_q) ? s1_a_q : s1_b_q;
      fpa_pkg::OpToInt:   s2_d.res = 32'(s1_a_q >>> FRAC_BITS);
      fpa_pkg::OpFromInt: s2_d.res = 32'(s1_a_q << FRAC_BITS);
      fpa_pkg::OpGt:      s2_d.cmp = (s1_a_q > s1_b_q);
      fpa_pkg::OpLt:      s2_d.cmp = (s1_a_q < s1_b_q);
      fpa_pkg::OpGe:      s2_d.cmp = (s1_a_q >= s1_b_q);
      fpa_pkg::OpLe:      s2_d.cmp = (s1_a_q <= s1_b_q);
      fpa_pkg::OpEq:      s2_d.cmp = (s1_a_q == s1_b_q);
      fpa_pkg::OpNe:      s2_d.cmp = (s1_a_q != s1_b_q);
      default:            s2_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q   <= s2_d;
    prod_q <= prod_d;
  end

  // ---- stage 3: product scaling, truncation toward zero
  stg_t        stg_q [QW+1];
  logic        vld_q [QW+1];
  stg_t        s3_d;
  logic [63:0] prod_bias;

  assign prod_bias = 64'(prod_q) + (prod_q[63] ? 64'((64'd1 << FRAC_BITS) - 64'd1) : 64'd0);

  always_comb begin
    s3_d = s2_q;
    if (s2_q.op == fpa_pkg::OpMul) begin
      s3_d.res = prod_bias[FRAC_BITS +: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    stg_q[0] <= s3_d;
  end

  // ---- divider: one restoring step per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    stg_t        nxt;
    logic [32:0] trial;
    logic        qbit;

    assign trial = {stg_q[j].rem, stg_q[j].num[QW-1]};
    assign qbit  = (trial >= {1'b0, stg_q[j].den});

    always_comb begin
      nxt     = stg_q[j];
      nxt.rem = qbit ? 32'(trial - {1'b0, stg_q[j].den}) : trial[31:0];
      nxt.num = {stg_q[j].num[QW-2:0], qbit};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      stg_q[j+1] <= nxt;
    end
  end

  // ---- output register
  logic [31:0] quo, res_d;
  logic        done_q, cmp_q, dz_q;
  logic [31:0] res_q;

  assign quo = stg_q[QW].num[31:0];

  always_comb begin
    res_d = stg_q[QW].res;
    if (stg_q[QW].op == fpa_pkg::OpDiv && !stg_q[QW].dz) begin
      res_d = stg_q[QW].neg ? 32'(-quo) : quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    cmp_q <= stg_q[QW].cmp;
    dz_q  <= stg_q[QW].dz;
  end

  assign done_o         = done_q;
  assign result_o       = res_q;
  assign compare_true_o = cmp_q;
  assign div_by_zero_o  = dz_q;

endmodule
`default_nettype wire

@@ rtl/core/fpa_checker.sv @@
// Port checker for the fixed-point ALU and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fpa_checker #(
  parameter int unsigned FRAC_BITS = fpa_pkg::FracBitsDef
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [31:0] result_o,
  input wire logic        compare_true_o,
  input wire logic        div_by_zero_o
);

  localparam int unsigned Lat = fpa_pkg::latency(FRAC_BITS);

  `FPA_ASSERT_ALWAYS(a_never_busy, !busy, clk_i)
  `FPA_ASSERT(a_item_done, start |-> ##Lat done_o, clk_i, rst_ni)
  `FPA_ASSERT(a_done_item, done_o |-> $past(start, Lat), clk_i, rst_ni)
  `FPA_ASSERT(a_dz_zero, div_by_zero_o && done_o |-> result_o == 32'd0 && !compare_true_o, clk_i, rst_ni)
  `FPA_ASSERT(a_cmp_zero, compare_true_o && done_o |-> result_o == 32'd0, clk_i, rst_ni)

endmodule

bind fixed_point_alu_core fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_fpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .result_o       (result_o),
  .compare_true_o (compare_true_o),
  .div_by_zero_o  (div_by_zero_o)
);
`default_nettype wire

@@ sim/testbench.sv @@
// Testbench for the fixed-point ALU core: directed table plus random items vs. a predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;

  localparam int unsigned FRAC = fpa_pkg::FracBitsDef;
  localparam int unsigned LAT = fpa_pkg::latency(FRAC);
  localparam int unsigned N_RANDOM = 1700;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [31:0] res;
    logic               cmp;
    logic               dz;
  } alu_out_t;

  typedef struct {
    logic [4:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic               known;  // expected value typed in below
    alu_out_t           want;
  } vec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [4:0] op_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic done_o;
  logic signed [31:0] result_o;
  logic compare_true_o;
  logic div_by_zero_o;

  alu_out_t pending_results[$];
  int errors = 0;
  longint unsigned cycles = 0;

  fixed_point_alu_core #(.FRAC_BITS(FRAC)) dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .operand_a_i, .operand_b_i,
    .done_o, .result_o, .compare_true_o, .div_by_zero_o
  );

  always #5 clk_i = ~clk_i;

  // Computes the ALU output for one item.
  function automatic alu_out_t alu_predict(logic [4:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_out_t r;
    logic signed [63:0] wa, wb, t;
    r = '0;
    wa = a;
    wb = b;
    case (op)
      fpa_pkg::OpAdd: r.res = a + b;
      fpa_pkg::OpSub: r.res = a - b;
      fpa_pkg::OpMul: begin
        t = (wa * wb) / (64'sd1 <<< FRAC);
        r.res = t[31:0];
      end
      fpa_pkg::OpDiv: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          t = (wa <<< FRAC) / wb;
          r.res = t[31:0];
        end
      end
      fpa_pkg::OpNeg: r.res = -a;
      fpa_pkg::OpInc: r.res = a + 32'sd1;
      fpa_pkg::OpDec: r.res = a - 32'sd1;
      fpa_pkg::OpMin: r.res = (a <= b) ? a : b;
      fpa_pkg::OpMax: r.res = (a >= b) ? a : b;
      fpa_pkg::OpToInt: r.res = a >>> FRAC;
      fpa_pkg::OpFromInt: r.res = a << FRAC;
      fpa_pkg::OpGt: r.cmp = a > b;
      fpa_pkg::OpLt: r.cmp = a < b;
      fpa_pkg::OpGe: r.cmp = a >= b;
      fpa_pkg::OpLe: r.cmp = a <= b;
      fpa_pkg::OpEq: r.cmp = a == b;
      fpa_pkg::OpNe: r.cmp = a != b;
      default: ;
    endcase
    return r;
  endfunction

  // Cycle counter and result checker, both on the rising edge.
  always @(posedge clk_i) begin
    alu_out_t exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %0d/%0b/%0b", $time, result_o,
                 compare_true_o, div_by_zero_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o !== exp_r.res) begin
          $display("%0t result: expected %0d actual %0d", $time, exp_r.res, result_o);
          errors++;
        end
        if (compare_true_o !== exp_r.cmp) begin
          $display("%0t compare_true: expected %0b actual %0b", $time, exp_r.cmp,
                   compare_true_o);
          errors++;
        end
        if (div_by_zero_o !== exp_r.dz) begin
          $display("%0t div_by_zero: expected %0b actual %0b", $time, exp_r.dz,
                   div_by_zero_o);
          errors++;
        end
      end
    end
  end

  // Drives one item at the falling edge and holds it until accepted.
  task automatic send_item(logic [4:0] op, logic signed [31:0] a, logic signed [31:0] b,
                           alu_out_t want);
    @(negedge clk_i);
    start <= 1'b1;
    op_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(want);
  endtask

  // Random operand biased toward edge values.
  function automatic logic signed [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 4)) - 32'sd2;
      4: return $signed($urandom_range(0, 4096)) - 32'sd2048;
      default: return $signed($urandom());
    endcase
  endfunction

  vec_t dir_tbl[$];

  initial begin
    logic [4:0] op;
    logic signed [31:0] a, b;
    int burst;
    alu_out_t z;
    bit drained;
    z = '0;
    drained = 1'b0;
    dir_tbl = '{
      '{fpa_pkg::OpAdd, 32'sh7fffffff, 32'sd1, 1'b1, '{32'sh80000000, 1'b0, 1'b0}},
      '{fpa_pkg::OpSub, 32'sh80000000, 32'sd1, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
      '{fpa_pkg::OpMul, 32'sh7fffffff, 32'sh80000000, 1'b0, z},
      '{fpa_pkg::OpMul, -32'sd1, 32'sd1, 1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{fpa_pkg::OpDiv, 32'sd256, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b1}},
      '{fpa_pkg::OpDiv, 32'sh80000000, -32'sd1, 1'b0, z},
      '{fpa_pkg::OpDiv, -32'sd1000, 32'sd3, 1'b0, z},
      '{fpa_pkg::OpNeg, 32'sh80000000, 32'sd5, 1'b1, '{32'sh80000000, 1'b0, 1'b0}},
      '{fpa_pkg::OpInc, 32'sh7fffffff, 32'sd0, 1'b1, '{32'sh80000000, 1'b0, 1'b0}},
      '{fpa_pkg::OpDec, 32'sh80000000, 32'sd0, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
      '{fpa_pkg::OpMin, 32'sd7, 32'sd7, 1'b1, '{32'sd7, 1'b0, 1'b0}},
      '{fpa_pkg::OpMax, 32'sh80000000, 32'sh7fffffff, 1'b1, '{32'sh7fffffff, 1'b0, 1'b0}},
      '{fpa_pkg::OpToInt, -32'sd1, 32'sd0, 1'b1, '{-32'sd1, 1'b0, 1'b0}},
      '{fpa_pkg::OpFromInt, 32'sh7fffffff, 32'sd0, 1'b1, '{-32'sd256, 1'b0, 1'b0}},
      '{fpa_pkg::OpGt, 32'sd0, 32'sh80000000, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{fpa_pkg::OpLt, 32'sh80000000, 32'sd0, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{fpa_pkg::OpGe, 32'sd4, 32'sd4, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{fpa_pkg::OpLe, 32'sd5, 32'sd4, 1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{fpa_pkg::OpEq, 32'sd9, 32'sd9, 1'b1, '{32'sd0, 1'b1, 1'b0}},
      '{fpa_pkg::OpNe, 32'sd9, 32'sd9, 1'b1, '{32'sd0, 1'b0, 1'b0}},
      '{5'd17, 32'sd1, 32'sd1, 1'b1, z},
      '{5'd31, -32'sd1, -32'sd1, 1'b1, z}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tbl[i])
      send_item(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b,
                dir_tbl[i].known ? dir_tbl[i].want
                                 : alu_predict(dir_tbl[i].op, dir_tbl[i].a, dir_tbl[i].b));

    for (int n = 0; n < N_RANDOM; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
        op = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31))
                                          : 5'($urandom_range(0, 16));
        a = pick_operand();
        b = ($urandom_range(0, 19) == 0) ? 32'sd0 : pick_operand();
        send_item(op, a, b, alu_predict(op, a, b));
      end
      if (!drained && n >= N_RANDOM / 2) begin
        // drain the pipe once mid-run
        drained = 1'b1;
        @(negedge clk_i);
        start <= 1'b0;
        wait (pending_results.size() == 0);
      end else if ($urandom_range(0, 2) != 0) begin
        @(negedge clk_i);
        start <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    start <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (LAT + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
